// ===== rtl/srdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srdp_pkg: shared types and constants of the stepper ramp divisor profile
// Field widths, register reset values, register indexes and action codes.
// ----------------------------------------------------------------------------
package srdp_pkg;

    // Widths of the configuration registers.
    localparam int TOTAL_STEPS_W = 24;
    localparam int START_DIV_W   = 12;
    localparam int MIN_DIV_W     = 12;
    localparam int ACCEL_DIST_W  = 16;
    localparam int ACCEL_STEP_W  = 10;

    // Configuration port.
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Widths of the result fields.
    localparam int ACTION_W    = 2;
    localparam int DIVISOR_W   = 12;
    localparam int STEPS_REM_W = 24;

    // Register values after reset.
    localparam logic [TOTAL_STEPS_W-1:0] TOTAL_STEPS_RST    = 24'd204800;
    localparam logic [START_DIV_W-1:0]   START_DIVISOR_RST  = 12'd1024;
    localparam logic [MIN_DIV_W-1:0]     MIN_DIVISOR_RST    = 12'd256;
    localparam logic [ACCEL_DIST_W-1:0]  ACCEL_DISTANCE_RST = 16'd600;
    localparam logic [ACCEL_STEP_W-1:0]  ACCEL_STEP_RST     = 10'd32;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOTAL_STEPS    = 3'd0,
        REG_START_DIVISOR  = 3'd1,
        REG_MIN_DIVISOR    = 3'd2,
        REG_ACCEL_DISTANCE = 3'd3,
        REG_ACCEL_STEP     = 3'd4
    } cfg_index_t;

    // What the step clock should do after an item.
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_STOP = 2'd2
    } action_t;

endpackage
`default_nettype wire

// ===== rtl/srdp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srdp_if: item channels of the stepper ramp divisor profile
// Valid/ready channels for step events in and ramp results out.
// ----------------------------------------------------------------------------
interface srdp_step_if;
    logic valid;
    logic ready;
    logic step_edge;

    modport source (output valid, output step_edge, input ready);
    modport sink (input valid, input step_edge, output ready);
endinterface

interface srdp_result_if;
    logic                                valid;
    logic                                ready;
    srdp_pkg::action_t                   action;
    logic [srdp_pkg::DIVISOR_W-1:0]      divisor;
    logic [srdp_pkg::STEPS_REM_W-1:0]    steps_remaining;

    modport source (output valid, output action, output divisor,
                    output steps_remaining, input ready);
    modport sink (input valid, input action, input divisor,
                  input steps_remaining, output ready);
endinterface
`default_nettype wire

// ===== rtl/stepper_ramp_divisor_profile_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_divisor_profile_unit: trapezoidal stepper ramp generator
// Turns step events into divisor loads and a stop request for a step clock.
// ----------------------------------------------------------------------------
// Each item on step_ch reports whether one step pulse happened. The unit
// counts steps done and steps left; far from the end of the move it lowers
// the clock divisor by accel_step every accel_distance steps while the new
// value stays above min_divisor, and near the end it raises it back towards
// start_divisor, which gives a trapezoidal speed profile. Once one or fewer
// steps remain, every pulse answers with a stop request. Every item gives
// exactly one result item with the action, the divisor and the steps left.
// The unit takes one item per clock cycle while results are taken. An
// accepted item sits in the input register, while compare-and-add logic
// works out the new move state; the state and the result register are
// loaded from there when the result register frees. A stalled result
// register holds the pipeline, while the input register still takes an
// item when it is empty. Any write on the configuration port to a valid
// register index restarts the move; writes belong in idle periods only.
// Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module stepper_ramp_divisor_profile_unit #(
    parameter int COUNT_WIDTH = 24,
    parameter int DIV_WIDTH   = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [srdp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [srdp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    srdp_step_if.sink                                step_ch,
    srdp_result_if.source                            result_ch
);

    localparam int TotW     = srdp_pkg::TOTAL_STEPS_W;
    localparam int StartW   = srdp_pkg::START_DIV_W;
    localparam int MinW     = srdp_pkg::MIN_DIV_W;
    localparam int DistW    = srdp_pkg::ACCEL_DIST_W;
    localparam int AstepW   = srdp_pkg::ACCEL_STEP_W;
    localparam int DivOutW  = srdp_pkg::DIVISOR_W;
    localparam int RemOutW  = srdp_pkg::STEPS_REM_W;

    // Working widths wide enough for every operand of a compare.
    localparam int CntExtW  = (COUNT_WIDTH > TotW) ? COUNT_WIDTH : TotW;
    localparam int SumW     = ((COUNT_WIDTH > DistW) ? COUNT_WIDTH : DistW) + 1;
    localparam int DivExtW  = (DIV_WIDTH > StartW) ? DIV_WIDTH : StartW;
    localparam int DivArW   = DivExtW + 2;

    localparam logic [COUNT_WIDTH-1:0] CountMax    = {COUNT_WIDTH{1'b1}};
    localparam logic [CntExtW-1:0]     CountMaxExt = CntExtW'(CountMax);
    localparam logic [SumW-1:0]        CountMaxSum = SumW'(CountMax);
    localparam logic [DivArW-1:0]      DivMaxAr    = DivArW'({DIV_WIDTH{1'b1}});
    localparam logic [DivExtW-1:0]     DivMaxExt   = DivExtW'({DIV_WIDTH{1'b1}});

    function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [CntExtW-1:0] v);
        return COUNT_WIDTH'((v > CountMaxExt) ? CountMaxExt : v);
    endfunction

    function automatic logic [DIV_WIDTH-1:0] sat_div(input logic [DivExtW-1:0] v);
        return DIV_WIDTH'((v > DivMaxExt) ? DivMaxExt : v);
    endfunction

    // Configuration registers.
    logic [TotW-1:0]   total_reg,  total_next;
    logic [StartW-1:0] start_reg,  start_next;
    logic [MinW-1:0]   min_reg,    min_next;
    logic [DistW-1:0]  dist_reg,   dist_next;
    logic [AstepW-1:0] astep_reg,  astep_next;
    logic              restart;

    // Move state.
    logic [COUNT_WIDTH-1:0] steps_done_reg, steps_done_next;
    logic [COUNT_WIDTH-1:0] steps_left_reg, steps_left_next;
    logic [COUNT_WIDTH-1:0] brake_mark_reg, brake_mark_next;
    logic [DIV_WIDTH-1:0]   cur_div_reg,    cur_div_next;

    // Input register and result register.
    logic                    s1_valid_reg;
    logic                    s1_step_reg;
    logic                    res_valid_reg;
    srdp_pkg::action_t       res_action_reg;
    logic [DivOutW-1:0]      res_div_reg;
    logic [RemOutW-1:0]      res_left_reg;

    logic                    advance;
    logic                    step_move;
    srdp_pkg::action_t       action_next;

    // The result register frees when it is empty or its item is taken; the
    // input register moves on in that case and otherwise only takes an item
    // while it is empty.
    assign advance       = !res_valid_reg || result_ch.ready;
    assign step_ch.ready = !s1_valid_reg || advance;
    assign step_move     = s1_valid_reg && advance;

    // Register writes; a write to any listed index restarts the move.
    always_comb
    begin
        total_next = total_reg;
        start_next = start_reg;
        min_next   = min_reg;
        dist_next  = dist_reg;
        astep_next = astep_reg;
        restart    = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                srdp_pkg::REG_TOTAL_STEPS:
                begin
                    total_next = TotW'(cfg_wdata);
                    restart    = 1'b1;
                end
                srdp_pkg::REG_START_DIVISOR:
                begin
                    start_next = StartW'(cfg_wdata);
                    restart    = 1'b1;
                end
                srdp_pkg::REG_MIN_DIVISOR:
                begin
                    min_next = MinW'(cfg_wdata);
                    restart  = 1'b1;
                end
                srdp_pkg::REG_ACCEL_DISTANCE:
                begin
                    dist_next = DistW'(cfg_wdata);
                    restart   = 1'b1;
                end
                srdp_pkg::REG_ACCEL_STEP:
                begin
                    astep_next = AstepW'(cfg_wdata);
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Ramp step: one pass of compares and adds on the item in the input
    // register and the current move state.
    always_comb
    begin
        logic [COUNT_WIDTH-1:0] done_inc;
        logic [COUNT_WIDTH-1:0] left_dec;
        logic [SumW-1:0]        mark_sum;
        logic signed [DivArW-1:0] lowered;
        logic [DivArW-1:0]      raised;

        done_inc = (steps_done_reg == CountMax) ? steps_done_reg
                                                : steps_done_reg + COUNT_WIDTH'(1);
        left_dec = (steps_left_reg != '0) ? steps_left_reg - COUNT_WIDTH'(1)
                                          : steps_left_reg;
        mark_sum = SumW'(brake_mark_reg) + SumW'(dist_reg);
        lowered  = $signed(DivArW'(cur_div_reg)) - $signed(DivArW'(astep_reg));
        raised   = DivArW'(cur_div_reg) + DivArW'(astep_reg);

        steps_done_next = steps_done_reg;
        steps_left_next = steps_left_reg;
        brake_mark_next = brake_mark_reg;
        cur_div_next    = cur_div_reg;
        action_next     = srdp_pkg::ACT_NONE;

        if (restart)
        begin
            // The user must write only while no item is in flight; the block itself does not enforce this.
            steps_done_next = '0;
            brake_mark_next = '0;
            steps_left_next = sat_count(CntExtW'(total_next));
            cur_div_next    = sat_div(DivExtW'(start_next));
        end
        else if (s1_valid_reg && s1_step_reg)
        begin
            steps_done_next = done_inc;
            steps_left_next = left_dec;
            if (left_dec <= COUNT_WIDTH'(1))
            begin
                action_next = srdp_pkg::ACT_STOP;
            end
            else if (SumW'(left_dec) > mark_sum)
            begin
                // Speeding up: lower the divisor while it stays above the floor.
                if ((lowered > $signed(DivArW'(min_reg))) &&
                    (mark_sum <= SumW'(done_inc)))
                begin
                    brake_mark_next = COUNT_WIDTH'((mark_sum > CountMaxSum) ? CountMaxSum
                                                                             : mark_sum);
                    cur_div_next    = DIV_WIDTH'(lowered);
                    action_next     = srdp_pkg::ACT_LOAD;
                end
            end
            else
            begin
                // Slowing down: climb back towards the start divisor.
                if ((DivExtW'(cur_div_reg) < DivExtW'(start_reg)) &&
                    (brake_mark_reg >= left_dec))
                begin
                    brake_mark_next = (SumW'(brake_mark_reg) > SumW'(dist_reg))
                                    ? COUNT_WIDTH'(SumW'(brake_mark_reg) - SumW'(dist_reg))
                                    : '0;
                    cur_div_next    = DIV_WIDTH'((raised > DivMaxAr) ? DivMaxAr : raised);
                    action_next     = srdp_pkg::ACT_LOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= srdp_pkg::TOTAL_STEPS_RST;
            start_reg      <= srdp_pkg::START_DIVISOR_RST;
            min_reg        <= srdp_pkg::MIN_DIVISOR_RST;
            dist_reg       <= srdp_pkg::ACCEL_DISTANCE_RST;
            astep_reg      <= srdp_pkg::ACCEL_STEP_RST;
            steps_done_reg <= '0;
            brake_mark_reg <= '0;
            steps_left_reg <= sat_count(CntExtW'(srdp_pkg::TOTAL_STEPS_RST));
            cur_div_reg    <= sat_div(DivExtW'(srdp_pkg::START_DIVISOR_RST));
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            start_reg <= start_next;
            min_reg   <= min_next;
            dist_reg  <= dist_next;
            astep_reg <= astep_next;
            if (restart || step_move)
            begin
                steps_done_reg <= steps_done_next;
                steps_left_reg <= steps_left_next;
                brake_mark_reg <= brake_mark_next;
                cur_div_reg    <= cur_div_next;
            end
            if (step_ch.ready)
            begin
                s1_valid_reg <= step_ch.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (step_ch.ready && step_ch.valid)
        begin
            s1_step_reg <= step_ch.step_edge;
        end
        if (step_move)
        begin
            res_action_reg <= action_next;
            res_div_reg    <= DivOutW'(cur_div_next);
            res_left_reg   <= RemOutW'(steps_left_next);
        end
    end

    assign result_ch.valid           = res_valid_reg;
    assign result_ch.action          = res_action_reg;
    assign result_ch.divisor         = res_div_reg;
    assign result_ch.steps_remaining = res_left_reg;

    // An item without a step pulse leaves the move untouched.
    a_idle_item_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (step_move && !s1_step_reg && !cfg_wr_en)
        |=> ($stable(cur_div_reg) && $stable(steps_left_reg) && $stable(brake_mark_reg)))
        else $error("idle item changed the move state");

    // A divisor change made by an item is reported as a load.
    a_div_change_is_load: assert property (@(posedge clk) disable iff (!rst_n)
        (step_move && !restart && (cur_div_next != cur_div_reg))
        |=> (res_action_reg == srdp_pkg::ACT_LOAD))
        else $error("divisor changed without a load result");

    // Steps left only grow through a restart.
    a_steps_left_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !restart |=> (steps_left_reg <= $past(steps_left_reg)))
        else $error("steps left grew without a restart");

    // With both registers full and the result stalled no item may enter.
    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result_ch.ready && s1_valid_reg) |-> !step_ch.ready)
        else $error("item accepted into a full stalled pipeline");

endmodule
`default_nettype wire
